[rtl/core/fba_pkg.sv]
// Package with constants, codes and types shared by the frame bitmap allocator.
package fba_pkg;

	localparam int FRAME_CAP   = 4096;
	localparam int WORD_BITS   = 32;
	localparam int MAP_WORDS   = FRAME_CAP / WORD_BITS;
	localparam int SCAN_BITS   = 8;
	localparam int SCAN_STEPS  = WORD_BITS / SCAN_BITS;
	localparam int FRAME_W     = $clog2(FRAME_CAP);
	localparam int CNT_W       = FRAME_W + 1;
	localparam int WADDR_W     = $clog2(MAP_WORDS);
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int STEP_W      = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;

	typedef logic [FRAME_W-1:0]   frame_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WADDR_W-1:0]   waddr_t;

	typedef enum logic [2:0] {
		MODE_ALLOC_ONE = 3'd0,
		MODE_ALLOC_RUN = 3'd1,
		MODE_FREE_RUN  = 3'd2,
		MODE_RELEASE   = 3'd3,
		MODE_RESERVE   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CNT_NONE,
		CNT_UP,
		CNT_DOWN
	} cnt_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_ZERO_RD,
		ST_ZERO_WR,
		ST_FIN
	} state_t;

endpackage

[rtl/core/frame_bitmap_allocator.sv]
// Frame bitmap allocator top level: request sequencer around the used-map RAM.
// Region and free operations read and then write back each map word touched; release and
// reserve then also mark frame zero used, and every request ends by posting the result.
// Allocation reads each map word and scans it 8 bits a cycle, then marks the run it finds.
// One request at a time; a finished result waits in the output register.
// Reset: all frames read as used through per-word valid flops, free count zero.
module frame_bitmap_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [fba_pkg::CNT_W-1:0] total_frames,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                mode,
	input  logic [fba_pkg::FRAME_W-1:0] frame_index,
	input  logic [fba_pkg::CNT_W-1:0] frame_count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      ok,
	output logic [fba_pkg::FRAME_W-1:0] alloc_frame,
	output logic [fba_pkg::CNT_W-1:0] free_frames
);

	fba_pkg::state_t  state_q, state_d;
	fba_pkg::cnt_op_t cop_q, cop_d;
	fba_pkg::cnt_t    total_q, lim;
	fba_pkg::cnt_t    fc_q, fc_d;
	fba_pkg::cnt_t    n_q, n_d, lo_q, lo_d, hi_q, hi_d, cur_q, cur_d;
	fba_pkg::cnt_t    base_q, base_d, run_q, run_d, done_q, done_d;
	fba_pkg::frame_t  start_q, start_d, where_q, where_d;
	logic [fba_pkg::STEP_W-1:0] k_q, k_d;
	logic             ok_q, ok_d, used_q, used_d, zf_q, zf_d;
	logic             out_valid_q, out_valid_d, ok_o_q, ok_o_d;
	fba_pkg::frame_t  alloc_o_q, alloc_o_d;
	fba_pkg::cnt_t    free_o_q, free_o_d;
	logic [fba_pkg::MAP_WORDS-1:0] vld_q;
	logic             vld_s1;

	logic             re, we;
	fba_pkg::waddr_t  raddr, waddr;
	fba_pkg::word_t   wdata, rdata, word;

	logic             sc_found, sc_end;
	fba_pkg::cnt_t    sc_run, sc_f;
	fba_pkg::frame_t  sc_start;
	logic [fba_pkg::SCAN_BITS-1:0] sc_bits;

	fba_pkg::word_t   mask;
	fba_pkg::cnt_t    nb, fj;
	logic [fba_pkg::CNT_W:0] sum_in, sum_fc;
	fba_pkg::cnt_t    hi_in, fc_new;

	assign lim       = (total_q > fba_pkg::CNT_W'(fba_pkg::FRAME_CAP)) ?
	                   fba_pkg::CNT_W'(fba_pkg::FRAME_CAP) : total_q;
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == fba_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign ok          = ok_o_q;
	assign alloc_frame = alloc_o_q;
	assign free_frames = free_o_q;
	assign word      = vld_s1 ? rdata : '1;

	fba_ram #(
		.WIDTH (fba_pkg::WORD_BITS),
		.DEPTH (fba_pkg::MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		sc_bits  = word[k_q*fba_pkg::SCAN_BITS +: fba_pkg::SCAN_BITS];
		sc_run   = run_q;
		sc_start = start_q;
		sc_found = 1'b0;
		sc_end   = 1'b0;
		sc_f     = '0;
		for (int j = 0; j < fba_pkg::SCAN_BITS; j++) begin
			sc_f = base_q + fba_pkg::CNT_W'(k_q) * fba_pkg::CNT_W'(fba_pkg::SCAN_BITS)
			       + fba_pkg::CNT_W'(j);
			if (!sc_found && !sc_end) begin
				if (sc_f >= lim) begin
					sc_end = 1'b1;
				end else if (sc_bits[j]) begin
					sc_run = '0;
				end else begin
					if (sc_run == '0) begin
						sc_start = sc_f[fba_pkg::FRAME_W-1:0];
					end
					sc_run = sc_run + 1'b1;
					if (sc_run == n_q) begin
						sc_found = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		fj = '0;
		for (int j = 0; j < fba_pkg::WORD_BITS; j++) begin
			fj = {1'b0, cur_q[fba_pkg::FRAME_W-1:fba_pkg::BIT_W], fba_pkg::BIT_W'(j)};
			mask[j] = (fj >= lo_q) && (fj < hi_q);
		end
	end

	assign nb = {cur_q[fba_pkg::CNT_W-1:fba_pkg::BIT_W] + 1'b1, {fba_pkg::BIT_W{1'b0}}};

	assign sum_in = {2'b00, frame_index} + {1'b0, frame_count};
	assign hi_in  = (sum_in > {1'b0, lim}) ? lim : sum_in[fba_pkg::CNT_W-1:0];
	assign sum_fc = {1'b0, fc_q} + {1'b0, done_q};

	always_comb begin
		case (cop_q)
			fba_pkg::CNT_UP:   fc_new = (sum_fc > {1'b0, lim}) ? lim :
			                            sum_fc[fba_pkg::CNT_W-1:0];
			fba_pkg::CNT_DOWN: fc_new = (done_q > fc_q) ? '0 : fc_q - done_q;
			default:           fc_new = fc_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		cop_d   = cop_q;
		fc_d    = fc_q;
		n_d     = n_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		cur_d   = cur_q;
		base_d  = base_q;
		run_d   = run_q;
		done_d  = done_q;
		start_d = start_q;
		where_d = where_q;
		k_d     = k_q;
		ok_d    = ok_q;
		used_d  = used_q;
		zf_d    = zf_q;
		out_valid_d = out_valid_q && !out_ready;
		ok_o_d    = ok_o_q;
		alloc_o_d = alloc_o_q;
		free_o_d  = free_o_q;
		re    = 1'b0;
		we    = 1'b0;
		raddr = cur_q[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
		waddr = cur_q[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
		wdata = used_q ? (word | mask) : (word & ~mask);
		case (state_q)
			fba_pkg::ST_IDLE: begin
				if (in_valid) begin
					where_d = '0;
					zf_d    = 1'b0;
					used_d  = 1'b1;
					base_d  = '0;
					run_d   = '0;
					k_d     = '0;
					case (mode)
						fba_pkg::MODE_ALLOC_ONE, fba_pkg::MODE_ALLOC_RUN: begin
							n_d    = (mode == fba_pkg::MODE_ALLOC_ONE) ?
							         fba_pkg::CNT_W'(1) : frame_count;
							done_d = '0;
							ok_d   = 1'b0;
							cop_d  = fba_pkg::CNT_NONE;
							if ((mode == fba_pkg::MODE_ALLOC_ONE) ? (fc_q == '0) :
							    (frame_count == '0 || fc_q <= frame_count)) begin
								state_d = fba_pkg::ST_FIN;
							end else begin
								state_d = fba_pkg::ST_SRCH_RD;
							end
						end
						fba_pkg::MODE_FREE_RUN, fba_pkg::MODE_RELEASE,
						fba_pkg::MODE_RESERVE: begin
							ok_d   = 1'b1;
							used_d = (mode == fba_pkg::MODE_RESERVE);
							cop_d  = (mode == fba_pkg::MODE_RESERVE) ?
							         fba_pkg::CNT_DOWN : fba_pkg::CNT_UP;
							zf_d   = (mode != fba_pkg::MODE_FREE_RUN) && (lim != '0);
							lo_d   = {1'b0, frame_index};
							hi_d   = hi_in;
							cur_d  = {1'b0, frame_index};
							if ({1'b0, frame_index} < hi_in) begin
								done_d  = hi_in - {1'b0, frame_index};
								state_d = fba_pkg::ST_MARK_RD;
							end else begin
								done_d  = '0;
								state_d = ((mode != fba_pkg::MODE_FREE_RUN) && (lim != '0)) ?
								          fba_pkg::ST_ZERO_RD : fba_pkg::ST_FIN;
							end
						end
						default: begin
							ok_d    = 1'b0;
							done_d  = '0;
							cop_d   = fba_pkg::CNT_NONE;
							state_d = fba_pkg::ST_FIN;
						end
					endcase
				end
			end
			fba_pkg::ST_SRCH_RD: begin
				re      = 1'b1;
				raddr   = base_q[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
				state_d = fba_pkg::ST_SRCH;
			end
			fba_pkg::ST_SRCH: begin
				run_d   = sc_run;
				start_d = sc_start;
				if (sc_found) begin
					lo_d    = {1'b0, sc_start};
					hi_d    = {1'b0, sc_start} + n_q;
					cur_d   = {1'b0, sc_start};
					where_d = sc_start;
					done_d  = n_q;
					ok_d    = 1'b1;
					cop_d   = fba_pkg::CNT_DOWN;
					state_d = fba_pkg::ST_MARK_RD;
				end else if (sc_end) begin
					state_d = fba_pkg::ST_FIN;
				end else if (k_q == fba_pkg::STEP_W'(fba_pkg::SCAN_STEPS - 1)) begin
					k_d = '0;
					if (base_q + fba_pkg::CNT_W'(fba_pkg::WORD_BITS) >= lim) begin
						state_d = fba_pkg::ST_FIN;
					end else begin
						base_d  = base_q + fba_pkg::CNT_W'(fba_pkg::WORD_BITS);
						state_d = fba_pkg::ST_SRCH_RD;
					end
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			fba_pkg::ST_MARK_RD: begin
				re      = 1'b1;
				state_d = fba_pkg::ST_MARK_WR;
			end
			fba_pkg::ST_MARK_WR: begin
				we = 1'b1;
				if (nb >= hi_q) begin
					state_d = zf_q ? fba_pkg::ST_ZERO_RD : fba_pkg::ST_FIN;
				end else begin
					cur_d   = nb;
					state_d = fba_pkg::ST_MARK_RD;
				end
			end
			fba_pkg::ST_ZERO_RD: begin
				re      = 1'b1;
				raddr   = '0;
				state_d = fba_pkg::ST_ZERO_WR;
			end
			fba_pkg::ST_ZERO_WR: begin
				we      = 1'b1;
				waddr   = '0;
				wdata   = word | fba_pkg::WORD_BITS'(1);
				state_d = fba_pkg::ST_FIN;
			end
			fba_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					fc_d        = fc_new;
					out_valid_d = 1'b1;
					ok_o_d      = ok_q;
					alloc_o_d   = where_q;
					free_o_d    = fc_new;
					state_d     = fba_pkg::ST_IDLE;
				end
			end
			default: state_d = fba_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fba_pkg::ST_IDLE;
			total_q     <= fba_pkg::CNT_W'(fba_pkg::FRAME_CAP);
			fc_q        <= '0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			vld_s1      <= 1'b0;
		end else begin
			state_q     <= state_d;
			fc_q        <= fc_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid) begin
				total_q <= total_frames;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld_s1 <= vld_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		cop_q     <= cop_d;
		n_q       <= n_d;
		lo_q      <= lo_d;
		hi_q      <= hi_d;
		cur_q     <= cur_d;
		base_q    <= base_d;
		run_q     <= run_d;
		done_q    <= done_d;
		start_q   <= start_d;
		where_q   <= where_d;
		k_q       <= k_d;
		ok_q      <= ok_d;
		used_q    <= used_d;
		zf_q      <= zf_d;
		ok_o_q    <= ok_o_d;
		alloc_o_q <= alloc_o_d;
		free_o_q  <= free_o_d;
	end

	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= fba_pkg::CNT_W'(fba_pkg::FRAME_CAP))
		else $error("free count above frame capacity");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == fba_pkg::ST_MARK_WR || state_q == fba_pkg::ST_ZERO_WR))
		else $error("map write outside a write state");

	a_zero_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fba_pkg::ST_ZERO_WR) |-> (waddr == '0 && wdata[0]))
		else $error("frame zero left free");

	a_alloc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fba_pkg::ST_FIN && cop_q == fba_pkg::CNT_DOWN && ok_q && used_q &&
		 !zf_q) |-> ({1'b0, where_q} < lim || lim == '0))
		else $error("allocated frame beyond limit");

endmodule

[rtl/core/fba_ram.sv]
// Generic simple dual-port RAM with registered read.
module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
